>>> rtl/core/itoa_pkg.sv
`default_nettype none

package itoa_pkg;

	// Format kinds carried on the input tuser
	localparam logic [2:0] KIND_UDEC = 3'd0;
	localparam logic [2:0] KIND_SDEC = 3'd1;
	localparam logic [2:0] KIND_HEX  = 3'd2;
	localparam logic [2:0] KIND_OCT  = 3'd3;
	localparam logic [2:0] KIND_BIN  = 3'd4;

	localparam int unsigned KIND_W   = 3;
	localparam int unsigned DATA_W   = 32;
	localparam int unsigned NB_W     = 6;
	localparam int unsigned S_TDATA_W = 40;
	localparam int unsigned CHAR_W   = 8;

	localparam logic [CHAR_W-1:0] ASCII_ZERO    = 8'd48;
	localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 8'h41;
	localparam logic [CHAR_W-1:0] ASCII_MINUS   = 8'h2D;

	// Digit buffer: ten BCD digits cover any 32-bit magnitude
	localparam int unsigned DEC_DIGITS = 10;
	localparam int unsigned WORK_W     = 4 * DEC_DIGITS;
	localparam int unsigned REM_W      = 6;
	localparam logic [REM_W-1:0] HEX_DIGITS = 6'd8;
	localparam logic [REM_W-1:0] OCT_DIGITS = 6'd11;
	localparam logic [REM_W-1:0] BIN_MAX    = 6'd32;

	typedef struct packed {
		logic load;
		logic dabble;
		logic seal;
		logic emit_sign;
		logic emit_digit;
		logic skip;
	} cmd_t;

	typedef struct packed {
		logic kind_ok;
		logic in_dec;
		logic neg;
		logic dabble_done;
		logic out_free;
		logic lead_zero;
		logic last_digit;
	} status_t;

endpackage

`default_nettype wire

>>> rtl/core/itoa_ctrl.sv
`default_nettype none

module itoa_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  s_tvalid,
	output logic                 s_tready,
	input  itoa_pkg::status_t    status,
	output itoa_pkg::cmd_t       cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SEAL,
		ST_SIGN,
		ST_RUN
	} state_t;

	state_t state_q;
	state_t state_next;
	logic   accept;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		cmd        = '0;
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load = accept;
				if (accept && status.kind_ok) begin
					state_next = status.in_dec ? ST_CONV : ST_RUN;
				end
			end
			ST_CONV: begin
				cmd.dabble = 1'b1;
				if (status.dabble_done) begin
					state_next = ST_SEAL;
				end
			end
			ST_SEAL: begin
				cmd.seal   = 1'b1;
				state_next = status.neg ? ST_SIGN : ST_RUN;
			end
			ST_SIGN: begin
				if (status.out_free) begin
					cmd.emit_sign = 1'b1;
					state_next    = ST_RUN;
				end
			end
			ST_RUN: begin
				if (status.lead_zero) begin
					cmd.skip = 1'b1;
				end else if (status.out_free) begin
					cmd.emit_digit = 1'b1;
					if (status.last_digit) begin
						state_next = ST_IDLE;
					end
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/itoa_dpath.sv
`default_nettype none

module itoa_dpath #(
	parameter int unsigned VALUE_WIDTH = 32
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  itoa_pkg::cmd_t                     cmd,
	input  wire [itoa_pkg::KIND_W-1:0]         in_kind,
	input  wire [itoa_pkg::DATA_W-1:0]         in_value,
	input  wire [itoa_pkg::NB_W-1:0]           in_bin_digits,
	input  wire                                out_ready,
	output itoa_pkg::status_t                  status,
	output logic [itoa_pkg::CHAR_W-1:0]        char_code,
	output logic                               last,
	output logic                               out_valid
);

	localparam int unsigned MAG_W   = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
	localparam bit          SIGN_ON = (VALUE_WIDTH <= 32);
	localparam int unsigned DCNT_W  = $clog2(MAG_W);
	localparam logic [31:0] VMASK   = (VALUE_WIDTH >= 32) ? 32'hFFFF_FFFF :
		32'((64'd1 << VALUE_WIDTH) - 64'd1);
	localparam int unsigned WW      = itoa_pkg::WORK_W;

	logic [31:0]                  v32;
	logic                         in_neg;
	logic [31:0]                  mag32;
	logic [itoa_pkg::NB_W-1:0]    nbs;
	logic [itoa_pkg::NB_W-1:0]    bin_shamt;
	logic [31:0]                  bin_al;
	logic [WW-1:0]                bcd_adj;
	logic                         bcd_ok;
	logic [3:0]                   digit;
	logic [itoa_pkg::CHAR_W-1:0]  digit_char;
	logic                         out_free;

	logic [MAG_W-1:0]             bin_q;
	logic [WW-1:0]                bcd_q;
	logic [DCNT_W-1:0]            dcnt_q;
	logic [WW-1:0]                work_q;
	logic [itoa_pkg::REM_W-1:0]   rem_q;
	logic [itoa_pkg::KIND_W-1:0]  kind_q;
	logic                         neg_q;
	logic                         started_q;
	logic [itoa_pkg::CHAR_W-1:0]  char_q;
	logic                         last_q;
	logic                         ovalid_q;

	// Input conditioning: mask to the value width, take the magnitude
	assign v32    = in_value & VMASK;
	assign in_neg = SIGN_ON && (in_kind == itoa_pkg::KIND_SDEC) && v32[MAG_W-1];
	assign mag32  = in_neg ? ((32'd0 - v32) & VMASK) : v32;

	always_comb begin
		if (in_bin_digits > itoa_pkg::BIN_MAX) begin
			nbs = itoa_pkg::BIN_MAX;
		end else if (in_bin_digits == '0) begin
			nbs = itoa_pkg::NB_W'(1);
		end else begin
			nbs = in_bin_digits;
		end
	end

	assign bin_shamt = itoa_pkg::BIN_MAX - nbs;
	assign bin_al    = v32 << bin_shamt;

	// Add-3 correction on every BCD digit before the shift
	always_comb begin
		bcd_ok = 1'b1;
		for (int i = 0; i < int'(itoa_pkg::DEC_DIGITS); i++) begin
			bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ?
				bcd_q[4*i +: 4] + 4'd3 : bcd_q[4*i +: 4];
			if (bcd_q[4*i +: 4] > 4'd9) begin
				bcd_ok = 1'b0;
			end
		end
	end

	// Top digit of the work register
	always_comb begin
		unique case (kind_q)
			itoa_pkg::KIND_BIN: digit = {3'b000, work_q[WW-1]};
			itoa_pkg::KIND_OCT: digit = {1'b0, work_q[WW-1 -: 3]};
			default:            digit = work_q[WW-1 -: 4];
		endcase
	end

	assign digit_char = (digit > 4'd9) ?
		itoa_pkg::ASCII_UPPER_A + {4'b0000, digit} - 8'd10 :
		itoa_pkg::ASCII_ZERO + {4'b0000, digit};

	assign out_free = !ovalid_q || out_ready;

	// A zero is only dropped before the first printed digit
	always_comb begin
		status             = '0;
		status.kind_ok     = (in_kind <= itoa_pkg::KIND_BIN);
		status.in_dec      = (in_kind == itoa_pkg::KIND_UDEC) ||
		                     (in_kind == itoa_pkg::KIND_SDEC);
		status.neg         = neg_q;
		status.dabble_done = (dcnt_q == DCNT_W'(MAG_W - 1));
		status.out_free    = out_free;
		status.last_digit  = (rem_q == itoa_pkg::REM_W'(1));
		status.lead_zero   = (digit == 4'd0) && !status.last_digit && !started_q &&
		                     (kind_q != itoa_pkg::KIND_BIN);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q    <= in_kind;
			neg_q     <= in_neg;
			started_q <= 1'b0;
			bin_q     <= mag32[MAG_W-1:0];
			bcd_q     <= '0;
			dcnt_q    <= '0;
			unique case (in_kind)
				itoa_pkg::KIND_HEX: begin
					work_q <= {v32, 8'h00};
					rem_q  <= itoa_pkg::HEX_DIGITS;
				end
				itoa_pkg::KIND_OCT: begin
					work_q <= {1'b0, v32, 7'h00};
					rem_q  <= itoa_pkg::OCT_DIGITS;
				end
				itoa_pkg::KIND_BIN: begin
					work_q <= {bin_al, 8'h00};
					rem_q  <= nbs;
				end
				default: begin
					work_q <= '0;
					rem_q  <= itoa_pkg::REM_W'(itoa_pkg::DEC_DIGITS);
				end
			endcase
		end else if (cmd.dabble) begin
			bcd_q  <= {bcd_adj[WW-2:0], bin_q[MAG_W-1]};
			bin_q  <= bin_q << 1;
			dcnt_q <= dcnt_q + DCNT_W'(1);
		end else if (cmd.seal) begin
			work_q <= bcd_q;
		end else if (cmd.skip || cmd.emit_digit) begin
			unique case (kind_q)
				itoa_pkg::KIND_BIN: work_q <= work_q << 1;
				itoa_pkg::KIND_OCT: work_q <= work_q << 3;
				default:            work_q <= work_q << 4;
			endcase
			rem_q <= rem_q - itoa_pkg::REM_W'(1);
			if (cmd.emit_digit) begin
				started_q <= 1'b1;
			end
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.emit_sign) begin
			char_q <= itoa_pkg::ASCII_MINUS;
			last_q <= 1'b0;
		end else if (cmd.emit_digit) begin
			char_q <= digit_char;
			last_q <= status.last_digit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (cmd.emit_sign || cmd.emit_digit) begin
			ovalid_q <= 1'b1;
		end else if (out_ready) begin
			ovalid_q <= 1'b0;
		end
	end

	assign char_code = char_q;
	assign last      = last_q;
	assign out_valid = ovalid_q;

	a_seal_bcd_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.seal |-> bcd_ok)
		else $error("BCD digit out of range after conversion");

	a_emit_needs_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_sign || cmd.emit_digit) |-> out_free)
		else $error("character written into an occupied output register");

	a_digit_count_live: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_digit || cmd.skip) |-> (rem_q != '0))
		else $error("digit emitted with no digits left");

	a_sign_only_negative: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_sign |-> (neg_q && ((kind_q == itoa_pkg::KIND_SDEC))))
		else $error("minus sign emitted for a non-negative number");

endmodule

`default_nettype wire

>>> rtl/core/integer_to_ascii_formatter.sv
`default_nettype none

// Integer to ASCII formatter. A request on the slave stream carries a number
// (s_tdata[31:0]), a binary digit count (s_tdata[37:32]) and a format kind
// (s_tuser: 0 unsigned decimal, 1 signed decimal, 2 upper-case hex, 3 octal,
// 4 binary); the master stream returns the characters most significant
// first, one per transfer, with m_tlast on the final one. Decimal, hex and
// octal drop leading zeros and print zero as a single '0'; a negative signed
// value gets a leading '-'. Binary prints exactly the digit count, saturated
// to 32, with zero treated as 1. Kinds 5 to 7 are accepted and produce
// nothing. Only the low VALUE_WIDTH bits of the number count, and the sign
// of a signed value sits at bit VALUE_WIDTH-1. One number is handled at a
// time: s_tready is high only while the block is idle. Hex, octal and binary
// are loaded and then sent digit by digit; decimal is loaded, converted by
// shift-and-add-3 over min(VALUE_WIDTH,32) bits, copied to the work
// register, then gives the sign of a negative value and steps through all
// ten digit positions, each suppressed or printed. The output register lets
// each character wait on m_tready without losing work already done.
module integer_to_ascii_formatter #(
	parameter int unsigned VALUE_WIDTH = 32
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	// slave request
	input  wire                                 s_tvalid,
	output logic                                s_tready,
	input  wire [itoa_pkg::S_TDATA_W-1:0]       s_tdata,  // value[31:0], bin_digits[37:32], pad
	input  wire [itoa_pkg::KIND_W-1:0]          s_tuser,  // kind[2:0]
	// master request
	output logic                                m_tvalid,
	input  wire                                 m_tready,
	output logic [itoa_pkg::CHAR_W-1:0]         m_tdata,  // char_code[7:0]
	output logic                                m_tlast
);

	itoa_pkg::cmd_t    cmd;
	itoa_pkg::status_t status;

	logic [itoa_pkg::DATA_W-1:0] in_value;
	logic [itoa_pkg::NB_W-1:0]   in_bin_digits;

	// Unpack the request; pad bits are ignored
	assign in_value      = s_tdata[itoa_pkg::DATA_W-1:0];
	assign in_bin_digits = s_tdata[itoa_pkg::DATA_W +: itoa_pkg::NB_W];

	// Sequencer: load, convert, seal, sign, skip leading zeros, one digit per free slot
	itoa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// Digit registers, BCD converter and output register
	itoa_dpath #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.in_kind       (s_tuser),
		.in_value      (in_value),
		.in_bin_digits (in_bin_digits),
		.out_ready     (m_tready),
		.status        (status),
		.char_code     (m_tdata),
		.last          (m_tlast),
		.out_valid     (m_tvalid)
	);

endmodule

`default_nettype wire
